[rtl/sab_pkg.sv]
package sab_pkg;

  localparam int TEX_TEXELS   = 65536;
  localparam int MAX_TEX_SIDE = 256;
  localparam int COORD_BITS   = 12;

  localparam int ADDR_W    = $clog2(TEX_TEXELS);
  localparam int SIDE_W    = $clog2(MAX_TEX_SIDE + 1);
  localparam int IDX_W     = $clog2(MAX_TEX_SIDE);
  localparam int COORD_W   = COORD_BITS;
  localparam int EDGE_W    = COORD_BITS + 2;
  localparam int POS_W     = 17;
  localparam int DIM_W     = 16;
  localparam int SCALE_W   = 24;
  localparam int TEXDIM_W  = 9;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int OFF_W     = COORD_BITS + 7;
  localparam int PROD_W    = OFF_W + SCALE_W + 1;
  localparam int PICK_SHIFT = 20;
  localparam int TEXEL_W   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_POS_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT  = 3'd7;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_BLEND = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [15:0]        texel_index;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       inside_rect;
  } out_word_t;

  typedef struct packed {
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
    logic               draw_en;
    logic [EDGE_W-1:0]  left;
    logic [EDGE_W-1:0]  right;
    logic [EDGE_W-1:0]  top;
    logic [EDGE_W-1:0]  bottom;
    logic [SIDE_W-1:0]  tw;
    logic [IDX_W-1:0]   tw_m1;
    logic [IDX_W-1:0]   th_m1;
  } setup_t;

  typedef struct packed {
    logic              blend;
    logic              hit;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
  } pix_t;

  typedef struct packed {
    logic               en;
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [TEXEL_W-1:0] wdata;
  } mem_req_t;

endpackage

[rtl/sab_ram.sv]
module sab_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[rtl/sab_addr.sv]
module sab_addr (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                item_valid,
  input  sab_pkg::in_word_t   item,
  input  sab_pkg::setup_t     setup,
  output logic                pix_valid,
  output sab_pkg::pix_t       pix,
  output sab_pkg::mem_req_t   req
);

  localparam int SUM_W = sab_pkg::ADDR_W + sab_pkg::SIDE_W + sab_pkg::IDX_W;

  function automatic logic [sab_pkg::IDX_W-1:0] pick(
    logic signed [sab_pkg::PROD_W-1:0] p,
    logic [sab_pkg::IDX_W-1:0] lim
  );
    logic [sab_pkg::PROD_W-sab_pkg::PICK_SHIFT-1:0] q;
    q = p[sab_pkg::PROD_W-1:sab_pkg::PICK_SHIFT];
    if (p[sab_pkg::PROD_W-1] || p == '0) begin
      return '0;
    end else if (q > (sab_pkg::PROD_W-sab_pkg::PICK_SHIFT)'(lim)) begin
      return lim;
    end else begin
      return q[sab_pkg::IDX_W-1:0];
    end
  endfunction

  // stage 0: captured word
  logic              v0;
  sab_pkg::in_word_t w0;

  // stage 1: offsets
  logic                               v1;
  sab_pkg::pix_t                      p1;
  logic signed [sab_pkg::OFF_W-1:0]   off_x;
  logic signed [sab_pkg::OFF_W-1:0]   off_y;

  // stage 2: scaled offsets
  logic                               v2;
  sab_pkg::pix_t                      p2;
  logic signed [sab_pkg::PROD_W-1:0]  prod_x;
  logic signed [sab_pkg::PROD_W-1:0]  prod_y;

  // stage 3: texel coordinates
  logic                      v3;
  sab_pkg::pix_t             p3;
  logic [sab_pkg::IDX_W-1:0] sx;
  logic [sab_pkg::IDX_W-1:0] sy;

  logic                              inside0;
  sab_pkg::pix_t                     p0;
  logic signed [sab_pkg::OFF_W-1:0]  off_x_next;
  logic signed [sab_pkg::OFF_W-1:0]  off_y_next;
  logic [SUM_W-1:0]                  sum;

  always_comb begin
    inside0 = setup.draw_en
      && (sab_pkg::EDGE_W'(w0.pixel_x) >= setup.left)
      && (sab_pkg::EDGE_W'(w0.pixel_x) < setup.right)
      && (sab_pkg::EDGE_W'(w0.pixel_y) >= setup.top)
      && (sab_pkg::EDGE_W'(w0.pixel_y) < setup.bottom);
    off_x_next = sab_pkg::OFF_W'($signed({1'b0, w0.pixel_x, 4'b0000}))
      - sab_pkg::OFF_W'($signed(setup.pos_x));
    off_y_next = sab_pkg::OFF_W'($signed({1'b0, w0.pixel_y, 4'b0000}))
      - sab_pkg::OFF_W'($signed(setup.pos_y));
    p0.blend  = (w0.cmd == sab_pkg::CMD_BLEND);
    p0.hit    = inside0;
    p0.addr   = sab_pkg::ADDR_W'(w0.texel_index);
    p0.red    = w0.red;
    p0.green  = w0.green;
    p0.blue   = w0.blue;
    p0.alpha  = w0.alpha_in;
  end

  always_comb begin
    sum = SUM_W'(sy) * SUM_W'(setup.tw) + SUM_W'(sx);
    pix_valid = v3;
    pix       = p3;
    req.en    = adv;
    req.we    = v3 && !p3.blend;
    req.addr  = p3.blend ? sum[sab_pkg::ADDR_W-1:0] : p3.addr;
    req.wdata = {p3.alpha, p3.blue, p3.green, p3.red};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v0 <= item_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
    if (adv) begin
      w0     <= item;
      p1     <= p0;
      off_x  <= off_x_next;
      off_y  <= off_y_next;
      p2     <= p1;
      prod_x <= off_x * $signed({1'b0, setup.scale_x});
      prod_y <= off_y * $signed({1'b0, setup.scale_y});
      p3     <= p2;
      sx     <= pick(prod_x, setup.tw_m1);
      sy     <= pick(prod_y, setup.th_m1);
    end
  end

endmodule

[rtl/sab_blend.sv]
module sab_blend (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                pix_valid,
  input  sab_pkg::pix_t                       pix,
  input  logic [sab_pkg::TEXEL_W-1:0]         rdata,
  output logic                                result_valid,
  output sab_pkg::out_word_t                  result
);

  function automatic logic [7:0] mix8(logic [7:0] d, logic [7:0] s, logic [7:0] a);
    logic signed [8:0]  diff;
    logic signed [17:0] p;
    diff = $signed({1'b0, s}) - $signed({1'b0, d});
    p = diff * $signed({1'b0, a});
    return d + p[15:8];
  endfunction

  logic               v4;
  sab_pkg::pix_t      p4;
  logic [7:0]         tr;
  logic [7:0]         tg;
  logic [7:0]         tb;
  logic [7:0]         ta;
  sab_pkg::out_word_t res_next;

  always_comb begin
    tr = rdata[7:0];
    tg = rdata[15:8];
    tb = rdata[23:16];
    ta = rdata[31:24];
    res_next.out_red     = p4.red;
    res_next.out_green   = p4.green;
    res_next.out_blue    = p4.blue;
    res_next.out_alpha   = p4.alpha;
    res_next.inside_rect = p4.hit;
    if (p4.hit) begin
      if (ta == 8'hff) begin
        res_next.out_red   = tr;
        res_next.out_green = tg;
        res_next.out_blue  = tb;
        res_next.out_alpha = 8'hff;
      end else if (ta != 8'h00) begin
        res_next.out_red   = mix8(p4.red, tr, ta);
        res_next.out_green = mix8(p4.green, tg, ta);
        res_next.out_blue  = mix8(p4.blue, tb, ta);
        res_next.out_alpha = mix8(p4.alpha, 8'hff, ta);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      v4           <= pix_valid;
      result_valid <= v4 && p4.blend;
    end
    if (adv) begin
      p4     <= pix;
      result <= res_next;
    end
  end

endmodule

[rtl/scaled_alpha_blit_unit.sv]
// channel  | signals                             | word
// item     | item_valid, item_ready, item        | texel load or canvas pixel
// result   | result_valid, result_ready, result  | blended canvas pixel
// config   | cfg_we, cfg_index, cfg_data         | one register write
// one word a cycle unless a held result stalls; a blend pixel's result is valid once its word has passed every stage
// six stages: capture, offsets, scale multiply, clamp, texture ram access, blend
// loads write the texture ram in the same stage where pixels read it, so order holds
// a held result stalls every stage; item_ready is high when no result is held or result_ready is high
// rst clears valids and resets the config registers; the texture ram keeps its contents
module scaled_alpha_blit_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  sab_pkg::in_word_t                 item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output sab_pkg::out_word_t                result,
  input  logic                              cfg_we,
  input  logic [sab_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sab_pkg::CFG_W-1:0]         cfg_data
);

  logic [sab_pkg::POS_W-1:0]    pos_x;
  logic [sab_pkg::POS_W-1:0]    pos_y;
  logic [sab_pkg::DIM_W-1:0]    draw_width;
  logic [sab_pkg::DIM_W-1:0]    draw_height;
  logic [sab_pkg::SCALE_W-1:0]  scale_x;
  logic [sab_pkg::SCALE_W-1:0]  scale_y;
  logic [sab_pkg::TEXDIM_W-1:0] tex_width;
  logic [sab_pkg::TEXDIM_W-1:0] tex_height;

  sab_pkg::setup_t   setup;
  sab_pkg::setup_t   setup_next;
  logic              adv;
  logic              pix_valid;
  sab_pkg::pix_t     pix;
  sab_pkg::mem_req_t req;
  logic [sab_pkg::TEXEL_W-1:0] rdata;

  logic signed [18:0] sum_r;
  logic signed [18:0] sum_b;
  logic [18:0]        lx;
  logic [18:0]        ty;
  logic [18:0]        rx;
  logic [18:0]        by;
  logic [sab_pkg::SIDE_W-1:0] tw;
  logic [sab_pkg::SIDE_W-1:0] th;

  assign adv        = !result_valid || result_ready;
  assign item_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x       <= '0;
      pos_y       <= '0;
      draw_width  <= '0;
      draw_height <= '0;
      scale_x     <= sab_pkg::SCALE_W'(65536);
      scale_y     <= sab_pkg::SCALE_W'(65536);
      tex_width   <= sab_pkg::TEXDIM_W'(1);
      tex_height  <= sab_pkg::TEXDIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        sab_pkg::REG_POS_X:       pos_x       <= cfg_data[sab_pkg::POS_W-1:0];
        sab_pkg::REG_POS_Y:       pos_y       <= cfg_data[sab_pkg::POS_W-1:0];
        sab_pkg::REG_DRAW_WIDTH:  draw_width  <= cfg_data[sab_pkg::DIM_W-1:0];
        sab_pkg::REG_DRAW_HEIGHT: draw_height <= cfg_data[sab_pkg::DIM_W-1:0];
        sab_pkg::REG_SCALE_X:     scale_x     <= cfg_data[sab_pkg::SCALE_W-1:0];
        sab_pkg::REG_SCALE_Y:     scale_y     <= cfg_data[sab_pkg::SCALE_W-1:0];
        sab_pkg::REG_TEX_WIDTH:   tex_width   <= cfg_data[sab_pkg::TEXDIM_W-1:0];
        sab_pkg::REG_TEX_HEIGHT:  tex_height  <= cfg_data[sab_pkg::TEXDIM_W-1:0];
        default: ;
      endcase
    end
  end

  // rounded edges, half away from zero; negative edges clip to zero
  always_comb begin
    sum_r = 19'($signed(pos_x)) + $signed({3'b000, draw_width});
    sum_b = 19'($signed(pos_y)) + $signed({3'b000, draw_height});
    lx = 19'($signed(pos_x)) + 19'sd8;
    ty = 19'($signed(pos_y)) + 19'sd8;
    rx = sum_r + 19'sd8;
    by = sum_b + 19'sd8;
    if (tex_width == '0) begin
      tw = sab_pkg::SIDE_W'(1);
    end else if (tex_width > sab_pkg::TEXDIM_W'(sab_pkg::MAX_TEX_SIDE)) begin
      tw = sab_pkg::SIDE_W'(sab_pkg::MAX_TEX_SIDE);
    end else begin
      tw = sab_pkg::SIDE_W'(tex_width);
    end
    if (tex_height == '0) begin
      th = sab_pkg::SIDE_W'(1);
    end else if (tex_height > sab_pkg::TEXDIM_W'(sab_pkg::MAX_TEX_SIDE)) begin
      th = sab_pkg::SIDE_W'(sab_pkg::MAX_TEX_SIDE);
    end else begin
      th = sab_pkg::SIDE_W'(tex_height);
    end
    setup_next.pos_x   = pos_x;
    setup_next.pos_y   = pos_y;
    setup_next.scale_x = scale_x;
    setup_next.scale_y = scale_y;
    setup_next.draw_en = (draw_width != '0) && (draw_height != '0);
    setup_next.left    = pos_x[sab_pkg::POS_W-1] ? '0 : sab_pkg::EDGE_W'(lx[18:4]);
    setup_next.top     = pos_y[sab_pkg::POS_W-1] ? '0 : sab_pkg::EDGE_W'(ty[18:4]);
    setup_next.right   = sum_r[18] ? '0 : sab_pkg::EDGE_W'(rx[18:4]);
    setup_next.bottom  = sum_b[18] ? '0 : sab_pkg::EDGE_W'(by[18:4]);
    setup_next.tw      = tw;
    setup_next.tw_m1   = sab_pkg::IDX_W'(tw - sab_pkg::SIDE_W'(1));
    setup_next.th_m1   = sab_pkg::IDX_W'(th - sab_pkg::SIDE_W'(1));
  end

  always_ff @(posedge clk) begin
    setup <= setup_next;
  end

  sab_addr u_addr (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item),
    .setup      (setup),
    .pix_valid  (pix_valid),
    .pix        (pix),
    .req        (req)
  );

  sab_ram #(
    .ADDR_W (sab_pkg::ADDR_W),
    .DATA_W (sab_pkg::TEXEL_W)
  ) u_ram (
    .clk   (clk),
    .en    (req.en),
    .we    (req.we),
    .addr  (req.addr),
    .wdata (req.wdata),
    .rdata (rdata)
  );

  sab_blend u_blend (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .pix_valid    (pix_valid),
    .pix          (pix),
    .rdata        (rdata),
    .result_valid (result_valid),
    .result       (result)
  );

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !item_ready)
    else $error("input taken while result held");

  a_result_on_advance: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_ready))
    else $error("result appeared without pipeline advance");

  a_ram_idle_on_stall: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> !req.en)
    else $error("texture ram accessed during stall");

endmodule
